>>> rtl/rlefd_pkg.sv
// shared types and constants for the run-length literal/fill decoder
`timescale 1ns / 1ps

package rlefd_pkg;

    localparam int FRAME_W = 18;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 18'd120000;
    localparam logic [6:0] LEN_MASK = 7'h7F;
    localparam int LITERAL_BIT = 7;

    // one job for the expander: a byte repeated count times
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       done;
    } run_t;

    // what the expander presents to the output register
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] byte_count;
        logic       last;
        logic       done;
    } result_t;

endpackage

>>> rtl/rle_literal_fill_decoder_core.sv
// top level of the run-length literal/fill decoder
//
//  channel | dir | handshake              | contents
//  s_      | in  | s_tvalid / s_tready    | compressed byte, start command in tuser
//  m_      | out | m_tvalid / m_tready    | one or two decoded bytes, run end, frame end
//  cfg_    | in  | cfg_valid / cfg_ready  | frame size in bytes, always ready
//
// a literal byte gives a one-byte result; a fill run of n bytes gives ceil(n/2) results of
// one or two bytes, and input stalls once the job queue (QUEUE_DEPTH entries) is full
// an accepted job goes through the job queue and then the output register
// reset restores the frame size to 120000 and empties the queue; a start command
// clears only the parser state, results already queued are still delivered
`timescale 1ns / 1ps

module rle_literal_fill_decoder_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte
    input  logic                          s_tuser,   // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // out_first, out_second, byte_count, zeros
    output logic                          m_tuser,   // frame_done
    output logic                          m_tlast,   // last_of_run
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlefd_pkg::FRAME_W-1:0] cfg_data
);

    logic               push;
    logic               push_ready;
    rlefd_pkg::run_t    push_run;
    logic               pop;
    logic               head_valid;
    rlefd_pkg::run_t    head;
    rlefd_pkg::result_t result;

    rlefd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_byte    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_run   (push_run),
        .push_ready (push_ready)
    );

    rlefd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    rlefd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {6'd0, result.byte_count, result.second, result.first};
    assign m_tuser = result.done;
    assign m_tlast = result.last;

endmodule

>>> rtl/rlefd_front.sv
// front end: parses headers, tracks frame position and issues expansion jobs
`timescale 1ns / 1ps

module rlefd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [7:0]                    in_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlefd_pkg::FRAME_W-1:0] cfg_data,
    output logic                          push,
    output rlefd_pkg::run_t               push_run,
    input  logic                          push_ready
);

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_FILL    = 2'd2
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic [7:0]                    run_left_reg, run_left_next;
    logic [rlefd_pkg::FRAME_W-1:0] bytes_out_reg, bytes_out_next;
    logic [rlefd_pkg::FRAME_W-1:0] frame_bytes_reg;
    logic [rlefd_pkg::FRAME_W-1:0] left;
    logic [rlefd_pkg::FRAME_W-1:0] bytes_plus_one;
    logic [rlefd_pkg::FRAME_W-1:0] run_wide;
    logic                          accept;
    logic                          full;
    logic [7:0]                    fill_n;
    logic                          fill_clip;

    assign in_ready  = push_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid & in_ready;
    assign full      = bytes_out_reg >= frame_bytes_reg;

    assign left           = frame_bytes_reg - bytes_out_reg;
    assign bytes_plus_one = bytes_out_reg + rlefd_pkg::FRAME_W'(1);
    assign run_wide       = rlefd_pkg::FRAME_W'(run_left_reg);
    // a fill run that reaches or crosses the frame end is cut there
    assign fill_clip      = run_wide >= left;
    assign fill_n         = fill_clip ? left[7:0] : run_left_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        run_left_next  = run_left_reg;
        bytes_out_next = bytes_out_reg;
        push           = 1'b0;
        push_run       = '{value: in_byte, count: 8'd1, done: 1'b0};
        if (accept)
        begin
            if (in_cmd)
            begin
                mode_next      = MODE_HEADER;
                run_left_next  = '0;
                bytes_out_next = '0;
            end
            else if (!full)
            begin
                case (mode_reg)
                    MODE_LITERAL:
                    begin
                        push           = 1'b1;
                        push_run.done  = bytes_plus_one >= frame_bytes_reg;
                        bytes_out_next = bytes_plus_one;
                        run_left_next  = run_left_reg - 8'd1;
                        if (run_left_reg == 8'd1)
                        begin
                            mode_next = MODE_HEADER;
                        end
                    end
                    MODE_FILL:
                    begin
                        push           = 1'b1;
                        push_run.count = fill_n;
                        push_run.done  = fill_clip;
                        bytes_out_next = bytes_out_reg + rlefd_pkg::FRAME_W'(fill_n);
                        run_left_next  = '0;
                        mode_next      = MODE_HEADER;
                    end
                    default:
                    begin
                        run_left_next = {1'b0, in_byte[6:0] & rlefd_pkg::LEN_MASK} + 8'd1;
                        mode_next     = in_byte[rlefd_pkg::LITERAL_BIT] ? MODE_LITERAL
                                                                        : MODE_FILL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_HEADER;
            run_left_reg    <= '0;
            bytes_out_reg   <= '0;
            frame_bytes_reg <= rlefd_pkg::FRAME_RESET;
        end
        else
        begin
            mode_reg      <= mode_next;
            run_left_reg  <= run_left_next;
            bytes_out_reg <= bytes_out_next;
            if (cfg_valid && cfg_ready)
            begin
                frame_bytes_reg <= cfg_data;
            end
        end
    end

endmodule

>>> rtl/rlefd_queue.sv
// short job queue between the parser and the expander
`timescale 1ns / 1ps

module rlefd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rlefd_pkg::run_t push_run,
    output logic            push_ready,
    input  logic            pop,
    output rlefd_pkg::run_t head,
    output logic            head_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rlefd_pkg::run_t slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign push_ready = fill_reg != CW'(DEPTH);
    assign head_valid = fill_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + CW'(1);
            2'b01:   fill_next = fill_reg - CW'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill count above depth");
`endif

endmodule

>>> rtl/rlefd_back.sv
// back end: expands jobs into one- or two-byte results behind an output register
`timescale 1ns / 1ps

module rlefd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  rlefd_pkg::run_t    head,
    input  logic               head_valid,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output rlefd_pkg::result_t out_result
);

    logic               active_reg, active_next;
    logic [7:0]         rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    rlefd_pkg::result_t result_reg, result_next;
    logic [7:0]         rem;
    logic [7:0]         rem_after;
    logic               pair;
    logic               advance;
    logic               take;

    assign advance   = !out_valid_reg | out_ready;
    assign take      = advance & head_valid;
    // a job is counted down in place while it sits at the head of the queue
    assign rem       = active_reg ? rem_reg : head.count;
    assign pair      = rem >= 8'd2;
    assign rem_after = rem - (pair ? 8'd2 : 8'd1);
    assign pop       = take & (rem_after == 8'd0);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        active_next    = active_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (advance)
        begin
            out_valid_next = head_valid;
        end
        if (take)
        begin
            result_next.first      = head.value;
            result_next.second     = pair ? head.value : 8'd0;
            result_next.byte_count = pair ? 2'd2 : 2'd1;
            result_next.last       = rem_after == 8'd0;
            result_next.done       = (rem_after == 8'd0) & head.done;
            active_next            = rem_after != 8'd0;
            rem_next               = rem_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.byte_count == 2'd1 || result_reg.byte_count == 2'd2))
        else $error("result with no decoded bytes");
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.done) |-> result_reg.last)
        else $error("frame end flagged on a result that does not close its run");
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.byte_count == 2'd1) |-> (result_reg.second == 8'd0))
        else $error("second lane not cleared on a one-byte result");
    a_pop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (!active_reg && out_valid_reg && result_reg.last))
        else $error("job left the queue without its closing result");
`endif

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the run-length literal/fill decoder core
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTED   = 40;
    localparam int NDIR          = 30;
    localparam int NPHASE        = 4;

    typedef enum logic [1:0] {
        AWAIT_HEADER = 2'd0,
        IN_LITERAL   = 2'd1,
        AWAIT_FILL   = 2'd2
    } dec_mode_t;

    // directed rows: a frame size write, a start command, or a data byte whose results are
    // typed in (none or exactly one) or left to the decoder model
    typedef enum logic [2:0] {
        ROW_CFG   = 3'd0,
        ROW_START = 3'd1,
        ROW_NONE  = 3'd2,
        ROW_ONE   = 3'd3,
        ROW_PRED  = 3'd4
    } row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [rlefd_pkg::FRAME_W-1:0] value;
        rlefd_pkg::result_t            want;
    } stim_row_t;

    localparam rlefd_pkg::result_t NO_RESULT = '0;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = 8'h00;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [23:0]                   m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rlefd_pkg::FRAME_W-1:0] cfg_data  = '0;

    // decoder model state
    dec_mode_t                     dec_mode    = AWAIT_HEADER;
    logic [7:0]                    run_left    = 8'd0;
    logic [7:0]                    fill_value  = 8'd0;
    logic [rlefd_pkg::FRAME_W-1:0] bytes_out   = '0;
    logic [rlefd_pkg::FRAME_W-1:0] frame_bytes = rlefd_pkg::FRAME_RESET;

    rlefd_pkg::result_t decoded_q[$];
    int                 errors       = 0;
    int                 fed_items    = 0;
    int unsigned        cycle_count  = 0;
    int                 hold_left    = 0;
    bit                 source_quiet = 1'b0;
    bit                 sink_quiet   = 1'b0;

    stim_row_t directed [NDIR] = '{
        '{ROW_START, 18'h00000, NO_RESULT},
        '{ROW_NONE,  18'h00080, NO_RESULT},
        '{ROW_ONE,   18'h00000, '{8'h00, 8'h00, 2'd1, 1'b1, 1'b0}},
        '{ROW_NONE,  18'h00081, NO_RESULT},
        '{ROW_ONE,   18'h000FF, '{8'hFF, 8'h00, 2'd1, 1'b1, 1'b0}},
        '{ROW_ONE,   18'h000A5, '{8'hA5, 8'h00, 2'd1, 1'b1, 1'b0}},
        '{ROW_NONE,  18'h00000, NO_RESULT},
        '{ROW_ONE,   18'h0005A, '{8'h5A, 8'h00, 2'd1, 1'b1, 1'b0}},
        '{ROW_NONE,  18'h0007F, NO_RESULT},
        '{ROW_PRED,  18'h000FF, NO_RESULT},
        '{ROW_NONE,  18'h00001, NO_RESULT},
        '{ROW_ONE,   18'h0003C, '{8'h3C, 8'h3C, 2'd2, 1'b1, 1'b0}},
        '{ROW_NONE,  18'h000FF, NO_RESULT},
        '{ROW_ONE,   18'h00012, '{8'h12, 8'h00, 2'd1, 1'b1, 1'b0}},
        // start in the middle of a literal run, data lane ignored
        '{ROW_START, 18'h000FF, NO_RESULT},
        '{ROW_NONE,  18'h00002, NO_RESULT},
        '{ROW_PRED,  18'h00081, NO_RESULT},
        '{ROW_CFG,   18'd1,     NO_RESULT},
        '{ROW_START, 18'h00000, NO_RESULT},
        '{ROW_NONE,  18'h00080, NO_RESULT},
        '{ROW_ONE,   18'h00011, '{8'h11, 8'h00, 2'd1, 1'b1, 1'b1}},
        // frame full: header and data dropped
        '{ROW_NONE,  18'h00080, NO_RESULT},
        '{ROW_NONE,  18'h00022, NO_RESULT},
        '{ROW_CFG,   18'd5,     NO_RESULT},
        '{ROW_START, 18'h0005A, NO_RESULT},
        // fill of six clipped to five at the frame end
        '{ROW_NONE,  18'h00005, NO_RESULT},
        '{ROW_PRED,  18'h00077, NO_RESULT},
        '{ROW_NONE,  18'h00033, NO_RESULT},
        '{ROW_CFG,   18'd131072, NO_RESULT},
        '{ROW_START, 18'h00000, NO_RESULT}
    };

    rle_literal_fill_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic report(input string msg);
        if (errors < MAX_PRINTED)
            $display("error at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    // advance the decoder model by one accepted input; queue the results when keep is set
    task automatic decode_step(input logic cmd, input logic [7:0] b, input bit keep);
        logic [rlefd_pkg::FRAME_W-1:0] room;
        logic [7:0]                    n;
        logic [1:0]                    c;
        rlefd_pkg::result_t            r;
        // a full frame drops every data byte
        if (cmd)
        begin
            dec_mode   = AWAIT_HEADER;
            run_left   = 8'd0;
            fill_value = 8'd0;
            bytes_out  = '0;
        end
        else if (bytes_out < frame_bytes && dec_mode == IN_LITERAL)
        begin
            bytes_out    = bytes_out + 1'b1;
            r.first      = b;
            r.second     = 8'h00;
            r.byte_count = 2'd1;
            r.last       = 1'b1;
            r.done       = (bytes_out >= frame_bytes);
            if (keep)
                decoded_q.push_back(r);
            run_left = run_left - 8'd1;
            if (run_left == 8'd0)
                dec_mode = AWAIT_HEADER;
        end
        else if (bytes_out < frame_bytes && dec_mode == AWAIT_FILL)
        begin
            room       = frame_bytes - bytes_out;
            n          = (room < rlefd_pkg::FRAME_W'(run_left)) ? room[7:0] : run_left;
            fill_value = b;
            while (n > 0)
            begin
                c            = (n >= 8'd2) ? 2'd2 : 2'd1;
                n            = n - 8'(c);
                bytes_out    = bytes_out + rlefd_pkg::FRAME_W'(c);
                r.first      = b;
                r.second     = (c == 2'd2) ? b : 8'h00;
                r.byte_count = c;
                r.last       = (n == 8'd0);
                r.done       = (bytes_out >= frame_bytes);
                if (keep)
                    decoded_q.push_back(r);
            end
            run_left = 8'd0;
            dec_mode = AWAIT_HEADER;
        end
        else if (bytes_out < frame_bytes)
        begin
            // header byte, also taken for an unused mode code
            run_left = {1'b0, b[6:0] & rlefd_pkg::LEN_MASK} + 8'd1;
            dec_mode = b[rlefd_pkg::LITERAL_BIT] ? IN_LITERAL : AWAIT_FILL;
        end
    endtask

    // offer one byte and wait for its transfer, then run the model on it
    task automatic feed(input logic cmd, input logic [7:0] b, input bit keep);
        int gap;
        if ($urandom_range(0, 39) == 0)
            source_quiet = !source_quiet;
        gap = source_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        decode_step(cmd, b, keep);
        fed_items++;
    endtask

    // frame size is only changed once the decoder has drained
    task automatic write_frame(input logic [rlefd_pkg::FRAME_W-1:0] v);
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        frame_bytes = v;
    endtask

    // mostly well-formed literal and fill packets, with starts, noise and cut-off runs
    task automatic run_random(input int target);
        int         first_item;
        int         pick;
        int         len7;
        logic [7:0] hdr;
        first_item = fed_items;
        while (fed_items - first_item < target)
        begin
            pick = $urandom_range(0, 99);
            if (bytes_out >= frame_bytes && pick < 70)
                feed(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            else if (pick < 5)
                feed(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            else if (pick < 10)
                feed(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            else
            begin
                len7 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 7);
                hdr  = {1'($urandom_range(0, 1)), 7'(len7)};
                feed(1'b0, hdr, 1'b1);
                if (hdr[rlefd_pkg::LITERAL_BIT])
                begin
                    for (int i = 0; i <= len7; i++)
                    begin
                        if ($urandom_range(0, 99) < 2)
                            break;
                        feed(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                    end
                end
                else
                    feed(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    task automatic check_result();
        rlefd_pkg::result_t want;
        if (decoded_q.size() == 0)
        begin
            report($sformatf("result %h with nothing expected", m_tdata[17:0]));
            return;
        end
        want = decoded_q.pop_front();
        if (m_tdata[7:0] != want.first)
            report($sformatf("out_first %h, expected %h", m_tdata[7:0], want.first));
        if (m_tdata[15:8] != want.second)
            report($sformatf("out_second %h, expected %h", m_tdata[15:8], want.second));
        if (m_tdata[17:16] != want.byte_count)
            report($sformatf("byte_count %0d, expected %0d", m_tdata[17:16],
                             want.byte_count));
        if (m_tlast != want.last)
            report($sformatf("last_of_run %b, expected %b", m_tlast, want.last));
        if (m_tuser != want.done)
            report($sformatf("frame_done %b, expected %b", m_tuser, want.done));
    endtask

    // result side
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0 || hold_left > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_left > 0)
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result();
        end
    end

    // input side
    initial
    begin
        logic [rlefd_pkg::FRAME_W-1:0] phase_frame [NPHASE];
        int                            phase_items [NPHASE];
        phase_frame = '{rlefd_pkg::FRAME_W'($urandom_range(30, 300)), 18'd131072,
                        rlefd_pkg::FRAME_W'($urandom_range(1, 8)),
                        rlefd_pkg::FRAME_W'($urandom_range(1, 131072))};
        phase_items = '{140, 110, 70, 110};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            case (directed[i].kind)
                ROW_CFG:   write_frame(directed[i].value);
                ROW_START: feed(1'b1, directed[i].value[7:0], 1'b0);
                ROW_PRED:  feed(1'b0, directed[i].value[7:0], 1'b1);
                ROW_ONE:
                begin
                    feed(1'b0, directed[i].value[7:0], 1'b0);
                    decoded_q.push_back(directed[i].want);
                end
                default:   feed(1'b0, directed[i].value[7:0], 1'b0);
            endcase
        end

        for (int p = 0; p < NPHASE; p++)
        begin
            write_frame(phase_frame[p]);
            if (phase_frame[p] == 18'd131072)
            begin
                // back-to-back input against a stalled output fills the job queue
                source_quiet = 1'b1;
                hold_left   <= HOLD_CYCLES;
            end
            run_random(phase_items[p]);
        end

        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
